// ===== rtl/core/star_gnomonic_projection_assert.svh =====
// Assertion macros shared by the block; clocked on clk_i, quiet while rst_ni is low.
`ifndef STAR_GNOMONIC_PROJECTION_ASSERT_SVH
`define STAR_GNOMONIC_PROJECTION_ASSERT_SVH

// Same-cycle implication.
`define SGP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sgp assertion failed");

// Next-cycle implication.
`define SGP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sgp assertion failed");

`endif

// ===== rtl/core/sgp_pkg.sv =====
package sgp_pkg;

  localparam int AngW        = 24;
  localparam int TrigW       = 18;
  localparam int CordW       = 34;
  localparam int ZW          = 24;
  localparam int CordicSteps = 20;
  localparam int NxW         = 2 * TrigW;
  localparam int DenW        = 38;
  localparam int TagW        = 16;
  localparam int PixW        = 11;
  localparam int NumW        = 62;
  localparam int QuoW        = 31;
  localparam int DmW         = DenW - 1;
  localparam int RemW        = DmW + QuoW;
  localparam int MW          = 32;
  localparam int ProdW       = MW + TrigW;
  localparam int SumW        = ProdW + 1;
  localparam int RotShift    = 24;
  localparam int RotW        = SumW - RotShift;

  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CordW-1:0] QOne       = 34'sd65536;
  localparam logic [QuoW-1:0]         QuoLim     = 31'h4000_0000;

  typedef enum logic [2:0] {
    CFG_AXIS_RA      = 3'd0,
    CFG_SIN_AXIS_DEC = 3'd1,
    CFG_COS_AXIS_DEC = 3'd2,
    CFG_SCALE_X      = 3'd3,
    CFG_SCALE_Y      = 3'd4,
    CFG_COS_ROLL     = 3'd5,
    CFG_SIN_ROLL     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [AngW-1:0]         axis_ra;
    logic signed [TrigW-1:0] sin_axis_dec;
    logic signed [TrigW-1:0] cos_axis_dec;
    logic [AngW-1:0]         scale_x;
    logic [AngW-1:0]         scale_y;
    logic signed [TrigW-1:0] cos_roll;
    logic signed [TrigW-1:0] sin_roll;
  } cfg_t;

  // Projection terms handed from front to back
  typedef struct packed {
    logic signed [DenW-1:0] den;
    logic signed [NxW-1:0]  nx;
    logic signed [DenW-1:0] ny;
    logic [TagW-1:0]        tag;
    logic                   last;
  } proj_t;

  typedef struct packed {
    logic [PixW-1:0] row;
    logic [PixW-1:0] col;
    logic            view;
    logic [TagW-1:0] tag;
    logic            last;
  } pix_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0]    z;
    logic [1:0]              q;
  } rot_t;

  typedef struct packed {
    logic signed [TrigW-1:0] c;
    logic signed [TrigW-1:0] s;
  } trig_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:       t = 24'sd2097152;
      1:       t = 24'sd1238021;
      2:       t = 24'sd654136;
      3:       t = 24'sd332050;
      4:       t = 24'sd166669;
      5:       t = 24'sd83416;
      6:       t = 24'sd41718;
      7:       t = 24'sd20860;
      8:       t = 24'sd10430;
      9:       t = 24'sd5215;
      10:      t = 24'sd2608;
      11:      t = 24'sd1304;
      12:      t = 24'sd652;
      13:      t = 24'sd326;
      14:      t = 24'sd163;
      15:      t = 24'sd81;
      16:      t = 24'sd41;
      17:      t = 24'sd20;
      18:      t = 24'sd10;
      19:      t = 24'sd5;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Split the angle into quadrant and residue about the quadrant centre
  function automatic rot_t rot_init(input logic [AngW-1:0] a);
    rot_t            r;
    logic [AngW-1:0] sh;
    sh  = a + 24'h20_0000;
    r.x = CordicGain;
    r.y = '0;
    r.z = $signed({2'b00, sh[21:0]}) - 24'sd2097152;
    r.q = sh[23:22];
    return r;
  endfunction

  function automatic rot_t cordic_step(input rot_t r, input int i);
    rot_t                    o;
    logic signed [CordW-1:0] dx;
    logic signed [CordW-1:0] dy;
    dx  = r.y >>> i;
    dy  = r.x >>> i;
    o.q = r.q;
    if (!r.z[ZW-1]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - atan_turn(i);
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + atan_turn(i);
    end
    return o;
  endfunction

  function automatic logic signed [TrigW-1:0] round_q16(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] t;
    t = (v + 34'sd8192) >>> 14;
    if (t > QOne) begin
      t = QOne;
    end else if (t < -QOne) begin
      t = -QOne;
    end
    return t[TrigW-1:0];
  endfunction

  function automatic trig_t rot_finish(input rot_t r);
    trig_t                   o;
    logic signed [TrigW-1:0] cr;
    logic signed [TrigW-1:0] sr;
    cr = round_q16(r.x);
    sr = round_q16(r.y);
    case (r.q)
      2'd0: begin
        o.c = cr;
        o.s = sr;
      end
      2'd1: begin
        o.c = -sr;
        o.s = cr;
      end
      2'd2: begin
        o.c = -cr;
        o.s = -sr;
      end
      default: begin
        o.c = sr;
        o.s = -cr;
      end
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/core/sgp_front.sv =====
module sgp_front import sgp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [AngW-1:0]        star_ra_i,
  input  logic signed [AngW-1:0] star_dec_i,
  input  logic [TagW-1:0]        tag_i,
  input  logic                   last_i,
  input  cfg_t                   cfg_i,
  output logic                   valid_o,
  output proj_t                  proj_o
);

  localparam int Stages = CordicSteps + 4;

  typedef struct packed {
    rot_t            dec;
    rot_t            ra;
    logic [TagW-1:0] tag;
    logic            last;
  } cst_t;

  typedef struct packed {
    trig_t           dec;
    trig_t           ra;
    logic [TagW-1:0] tag;
    logic            last;
  } fin_t;

  typedef struct packed {
    logic signed [2*TrigW-1:0] p_ss;
    logic signed [2*TrigW-1:0] p_cc;
    logic signed [2*TrigW-1:0] p_sc;
    logic signed [2*TrigW-1:0] p_cs;
    logic signed [NxW-1:0]     nx;
    logic signed [TrigW-1:0]   ca;
    logic [TagW-1:0]           tag;
    logic                      last;
  } prd_t;

  logic [Stages-1:0]        v_q;
  cst_t                     cs_q [CordicSteps+1];
  fin_t                     fin_q;
  prd_t                     prd_q;
  proj_t                    proj_q;
  logic signed [TrigW+1:0]  cc_h;
  logic signed [TrigW+1:0]  cs_h;
  logic signed [DenW-1:0]   den_d;
  logic signed [DenW-1:0]   ny_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Stages-2:0], valid_i};
    end
  end

  // Floor of the Q32 product by 2^16, then one multiply and an add or subtract
  always_comb begin
    cc_h  = prd_q.p_cc[2*TrigW-1:16];
    cs_h  = prd_q.p_cs[2*TrigW-1:16];
    den_d = prd_q.p_ss + cc_h * prd_q.ca;
    ny_d  = prd_q.p_sc - cs_h * prd_q.ca;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs_q[0].dec  <= rot_init($unsigned(star_dec_i));
      cs_q[0].ra   <= rot_init(star_ra_i - cfg_i.axis_ra);
      cs_q[0].tag  <= tag_i;
      cs_q[0].last <= last_i;
      for (int i = 0; i < CordicSteps; i++) begin
        cs_q[i+1].dec  <= cordic_step(cs_q[i].dec, i);
        cs_q[i+1].ra   <= cordic_step(cs_q[i].ra, i);
        cs_q[i+1].tag  <= cs_q[i].tag;
        cs_q[i+1].last <= cs_q[i].last;
      end
      fin_q.dec  <= rot_finish(cs_q[CordicSteps].dec);
      fin_q.ra   <= rot_finish(cs_q[CordicSteps].ra);
      fin_q.tag  <= cs_q[CordicSteps].tag;
      fin_q.last <= cs_q[CordicSteps].last;
      prd_q.p_ss <= fin_q.dec.s * cfg_i.sin_axis_dec;
      prd_q.p_cc <= fin_q.dec.c * cfg_i.cos_axis_dec;
      prd_q.p_sc <= fin_q.dec.s * cfg_i.cos_axis_dec;
      prd_q.p_cs <= fin_q.dec.c * cfg_i.sin_axis_dec;
      prd_q.nx   <= fin_q.dec.c * fin_q.ra.s;
      prd_q.ca   <= fin_q.ra.c;
      prd_q.tag  <= fin_q.tag;
      prd_q.last <= fin_q.last;
      proj_q.den  <= den_d;
      proj_q.ny   <= ny_d;
      proj_q.nx   <= prd_q.nx;
      proj_q.tag  <= prd_q.tag;
      proj_q.last <= prd_q.last;
    end
  end

  assign valid_o = v_q[Stages-1];
  assign proj_o  = proj_q;

endmodule

// ===== rtl/core/sgp_fifo.sv =====
module sgp_fifo import sgp_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  proj_t      data_i,
  input  logic       pop_i,
  output proj_t      data_o,
  output fifo_stat_t stat_o
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  proj_t         mem_q [Depth];
  logic [AW-1:0] wr_q;
  logic [AW-1:0] rd_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== rtl/core/sgp_back.sv =====
module sgp_back import sgp_pkg::*; #(
  parameter int IMG_W = 1024,
  parameter int IMG_H = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  proj_t proj_i,
  input  cfg_t  cfg_i,
  output logic  valid_o,
  output pix_t  pix_o
);

  localparam int HalfW  = IMG_W / 2;
  localparam int HalfH  = IMG_H / 2;
  localparam int Stages = QuoW + 7;
  localparam int LoW    = 17;

  typedef struct packed {
    logic signed [AngW+LoW:0]              pxl;
    logic signed [AngW+NxW-LoW:0]          pxh;
    logic signed [AngW+LoW:0]              pyl;
    logic signed [AngW+DenW-LoW:0]         pyh;
    logic signed [DenW-1:0]                den;
    logic [TagW-1:0]                       tag;
    logic                                  last;
  } b1_t;

  typedef struct packed {
    logic signed [NumW-1:0] numx;
    logic signed [NumW-1:0] numy;
    logic signed [DenW-1:0] den;
    logic [TagW-1:0]        tag;
    logic                   last;
  } b2_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            sat;
  } ax_t;

  typedef struct packed {
    logic            pos;
    logic [DmW-1:0]  dm;
    ax_t             ax;
    ax_t             ay;
    logic [TagW-1:0] tag;
    logic            last;
  } dv_t;

  typedef struct packed {
    logic                  pos;
    logic signed [MW-1:0]  mx;
    logic signed [MW-1:0]  my;
    logic [TagW-1:0]       tag;
    logic                  last;
  } r1_t;

  typedef struct packed {
    logic                    pos;
    logic signed [ProdW-1:0] xc;
    logic signed [ProdW-1:0] ys;
    logic signed [ProdW-1:0] yc;
    logic signed [ProdW-1:0] xs;
    logic [TagW-1:0]         tag;
    logic                    last;
  } r2_t;

  typedef struct packed {
    logic                   pos;
    logic signed [SumW-1:0] sx;
    logic signed [SumW-1:0] sy;
    logic [TagW-1:0]        tag;
    logic                   last;
  } r3_t;

  function automatic ax_t ax_start(input logic signed [NumW-1:0] num, input logic [DmW-1:0] dm);
    ax_t             a;
    logic [NumW-1:0] mag;
    mag   = num[NumW-1] ? $unsigned(-num) : $unsigned(num);
    a.neg = num[NumW-1];
    a.rem = RemW'(mag);
    a.quo = '0;
    a.sat = (RemW'(mag) >= (RemW'(dm) << QuoW));
    return a;
  endfunction

  // One restoring quotient bit
  function automatic ax_t ax_step(input ax_t a, input logic [DmW-1:0] dm, input int b);
    ax_t             o;
    logic [RemW-1:0] trial;
    o     = a;
    trial = RemW'(dm) << b;
    if (a.rem >= trial) begin
      o.rem    = a.rem - trial;
      o.quo[b] = 1'b1;
    end
    return o;
  endfunction

  function automatic logic signed [MW-1:0] ax_out(input ax_t a);
    logic [QuoW-1:0]      mag;
    logic signed [MW-1:0] m;
    mag = (a.sat || (a.quo > QuoLim)) ? QuoLim : a.quo;
    m   = $signed({1'b0, mag});
    if (a.neg) begin
      m = -m;
    end
    return m + 32'sd128;
  endfunction

  function automatic logic signed [RotW-1:0] trunc_rot(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] t;
    t = s[SumW-1] ? s + SumW'((1 << RotShift) - 1) : s;
    return t[SumW-1:RotShift];
  endfunction

  logic [Stages-1:0]      v_q;
  b1_t                    b1_q;
  b2_t                    b2_q;
  dv_t                    dv_q [QuoW+1];
  r1_t                    r1_q;
  r2_t                    r2_q;
  r3_t                    r3_q;
  pix_t                   pix_q;
  logic                   pos_d;
  logic [DmW-1:0]         dm_d;
  logic signed [RotW-1:0] xr;
  logic signed [RotW-1:0] yr;
  logic                   win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Stages-2:0], valid_i};
    end
  end

  always_comb begin
    pos_d = !b2_q.den[DenW-1] && (b2_q.den != '0);
    dm_d  = pos_d ? b2_q.den[DmW-1:0] : DmW'(1);
    xr    = trunc_rot(r3_q.sx);
    yr    = trunc_rot(r3_q.sy);
    win   = r3_q.pos && (xr > -HalfW) && (xr <= HalfW) && (yr >= -HalfH) && (yr < HalfH);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Split the numerators so each multiply stays narrow
      b1_q.pxl  <= $signed({1'b0, cfg_i.scale_x}) * $signed({1'b0, proj_i.nx[LoW-1:0]});
      b1_q.pxh  <= $signed({1'b0, cfg_i.scale_x}) * $signed(proj_i.nx[NxW-1:LoW]);
      b1_q.pyl  <= $signed({1'b0, cfg_i.scale_y}) * $signed({1'b0, proj_i.ny[LoW-1:0]});
      b1_q.pyh  <= $signed({1'b0, cfg_i.scale_y}) * $signed(proj_i.ny[DenW-1:LoW]);
      b1_q.den  <= proj_i.den;
      b1_q.tag  <= proj_i.tag;
      b1_q.last <= proj_i.last;

      b2_q.numx <= (NumW'(b1_q.pxh) <<< LoW) + NumW'(b1_q.pxl);
      b2_q.numy <= (NumW'(b1_q.pyh) <<< LoW) + NumW'(b1_q.pyl);
      b2_q.den  <= b1_q.den;
      b2_q.tag  <= b1_q.tag;
      b2_q.last <= b1_q.last;

      dv_q[0].pos  <= pos_d;
      dv_q[0].dm   <= dm_d;
      dv_q[0].ax   <= ax_start(b2_q.numx, dm_d);
      dv_q[0].ay   <= ax_start(b2_q.numy, dm_d);
      dv_q[0].tag  <= b2_q.tag;
      dv_q[0].last <= b2_q.last;
      for (int k = 0; k < QuoW; k++) begin
        dv_q[k+1].pos  <= dv_q[k].pos;
        dv_q[k+1].dm   <= dv_q[k].dm;
        dv_q[k+1].ax   <= ax_step(dv_q[k].ax, dv_q[k].dm, QuoW - 1 - k);
        dv_q[k+1].ay   <= ax_step(dv_q[k].ay, dv_q[k].dm, QuoW - 1 - k);
        dv_q[k+1].tag  <= dv_q[k].tag;
        dv_q[k+1].last <= dv_q[k].last;
      end

      r1_q.pos  <= dv_q[QuoW].pos;
      r1_q.mx   <= ax_out(dv_q[QuoW].ax);
      r1_q.my   <= ax_out(dv_q[QuoW].ay);
      r1_q.tag  <= dv_q[QuoW].tag;
      r1_q.last <= dv_q[QuoW].last;

      r2_q.pos  <= r1_q.pos;
      r2_q.xc   <= r1_q.mx * cfg_i.cos_roll;
      r2_q.ys   <= r1_q.my * cfg_i.sin_roll;
      r2_q.yc   <= r1_q.my * cfg_i.cos_roll;
      r2_q.xs   <= r1_q.mx * cfg_i.sin_roll;
      r2_q.tag  <= r1_q.tag;
      r2_q.last <= r1_q.last;

      r3_q.pos  <= r2_q.pos;
      r3_q.sx   <= SumW'(r2_q.xc) + SumW'(r2_q.ys);
      r3_q.sy   <= SumW'(r2_q.yc) - SumW'(r2_q.xs);
      r3_q.tag  <= r2_q.tag;
      r3_q.last <= r2_q.last;

      pix_q.view <= win;
      pix_q.row  <= win ? PixW'(HalfH - int'(yr)) : '0;
      pix_q.col  <= win ? PixW'(HalfW + int'(xr)) : '0;
      pix_q.tag  <= r3_q.tag;
      pix_q.last <= r3_q.last;
    end
  end

  assign valid_o = v_q[Stages-1];
  assign pix_o   = pix_q;

endmodule

// ===== rtl/core/star_gnomonic_projection.sv =====
// Channel    Dir  Payload
// s_axis     in   star_ra, star_dec, star_tag; tlast = last_in_list
// m_axis     out  pixel_row, pixel_col, tag_out; tuser = in_view; tlast = last_out
// cfg        in   register index and write data, always ready
//
// One star per cycle sustained while the output is not backpressured.
// The front (20-step CORDIC pair and projection products) feeds the queue, and the
// queue feeds the back (scaling, 31-stage restoring divider pair, roll, window).
// Reset clears pipeline valids, queue pointers and the config registers to their defaults.
// The front stalls only when the queue is full; the back only on output backpressure.
`include "star_gnomonic_projection_assert.svh"

module star_gnomonic_projection import sgp_pkg::*; #(
  parameter int IMG_W      = 1024,
  parameter int IMG_H      = 1024,
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // star_ra[23:0], star_dec[47:24], star_tag[63:48]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // pixel_row[10:0], pixel_col[21:11], tag_out[37:22]
  output logic [0:0]  m_axis_tuser_o,  // in_view[0]
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  cfg_t       cfg_q;
  logic       front_en;
  logic       front_valid;
  proj_t      front_proj;
  logic       fifo_push;
  logic       fifo_pop;
  proj_t      fifo_data;
  fifo_stat_t fifo_stat;
  logic       back_en;
  logic       back_valid;
  pix_t       back_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_ra      <= 24'd0;
      cfg_q.sin_axis_dec <= 18'sd0;
      cfg_q.cos_axis_dec <= 18'sd65536;
      cfg_q.scale_x      <= 24'd995610;
      cfg_q.scale_y      <= 24'd995610;
      cfg_q.cos_roll     <= 18'sd65536;
      cfg_q.sin_roll     <= 18'sd0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AXIS_RA:      cfg_q.axis_ra      <= cfg_data_i;
        CFG_SIN_AXIS_DEC: cfg_q.sin_axis_dec <= cfg_data_i[TrigW-1:0];
        CFG_COS_AXIS_DEC: cfg_q.cos_axis_dec <= cfg_data_i[TrigW-1:0];
        CFG_SCALE_X:      cfg_q.scale_x      <= cfg_data_i;
        CFG_SCALE_Y:      cfg_q.scale_y      <= cfg_data_i;
        CFG_COS_ROLL:     cfg_q.cos_roll     <= cfg_data_i[TrigW-1:0];
        CFG_SIN_ROLL:     cfg_q.sin_roll     <= cfg_data_i[TrigW-1:0];
        default: ;
      endcase
    end
  end

  // Hold the front while its finished item has no room in the queue
  assign front_en  = !(front_valid && fifo_stat.full);
  assign fifo_push = front_valid && front_en;
  assign back_en   = !back_valid || m_axis_tready_i;
  assign fifo_pop  = back_en && !fifo_stat.empty;

  sgp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (front_en),
    .valid_i    (s_axis_tvalid_i),
    .star_ra_i  (s_axis_tdata_i[23:0]),
    .star_dec_i ($signed(s_axis_tdata_i[47:24])),
    .tag_i      (s_axis_tdata_i[63:48]),
    .last_i     (s_axis_tlast_i),
    .cfg_i      (cfg_q),
    .valid_o    (front_valid),
    .proj_o     (front_proj)
  );

  sgp_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .data_i (front_proj),
    .pop_i  (fifo_pop),
    .data_o (fifo_data),
    .stat_o (fifo_stat)
  );

  sgp_back #(
    .IMG_W (IMG_W),
    .IMG_H (IMG_H)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (back_en),
    .valid_i (fifo_pop),
    .proj_i  (fifo_data),
    .cfg_i   (cfg_q),
    .valid_o (back_valid),
    .pix_o   (back_pix)
  );

  assign s_axis_tready_o   = front_en;
  assign cfg_ready_o       = 1'b1;
  assign m_axis_tvalid_o   = back_valid;
  assign m_axis_tdata_o    = {2'b00, back_pix.tag, back_pix.col, back_pix.row};
  assign m_axis_tuser_o[0] = back_pix.view;
  assign m_axis_tlast_o    = back_pix.last;

  `SGP_ASSERT_IMP(a_push_has_room, fifo_push, !fifo_stat.full)
  `SGP_ASSERT_IMP(a_pop_has_data, fifo_pop, !fifo_stat.empty)
  `SGP_ASSERT_NEXT(a_front_holds, front_valid && !front_en, front_valid)
  `SGP_ASSERT_IMP(a_hidden_is_zero, back_valid && !back_pix.view, back_pix.row == '0 && back_pix.col == '0)

endmodule
